FILE: src/esc_exp_pkg.sv
// ----------------------------------------------------------------------------
// esc_exp_pkg
// Shared types and constants for the backslash escape expander.
// ----------------------------------------------------------------------------
package esc_exp_pkg;

   // Payload types
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] error_code;
      logic       end_of_string;
   } rsp_type;

   // Result error codes
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_UNKNOWN_ESC = 3'd1;
   localparam logic [2:0] ERR_BAD_HEX     = 3'd2;
   localparam logic [2:0] ERR_ESC_CUT     = 3'd3;
   localparam logic [2:0] ERR_HEX_CUT     = 3'd4;
   localparam logic [2:0] ERR_LENGTH      = 3'd5;

   // Output byte counter / length limit
   localparam int unsigned COUNT_W = 31;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // CSR map
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic        CSR_IDX_MAX_LENGTH = 1'b0;

   // Character codes
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] BYTE_NUL       = 8'h00;
   localparam logic [7:0] BYTE_LF        = 8'h0A;
   localparam logic [7:0] BYTE_TAB       = 8'h09;
   localparam logic [7:0] BYTE_CR        = 8'h0D;

endpackage

FILE: src/esc_exp_decode.sv
// ----------------------------------------------------------------------------
// esc_exp_decode
// Escape decoder state and one-byte next-state / result logic.
// ----------------------------------------------------------------------------
module esc_exp_decode (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_accept,
   input  esc_exp_pkg::req_type               req_payload,
   input  logic [esc_exp_pkg::COUNT_W-1:0]    max_length,
   output logic                               res_valid,
   output esc_exp_pkg::rsp_type               res_payload
);

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_ESC    = 3'd1,
      MODE_HEX1   = 3'd2,
      MODE_HEX2   = 3'd3,
      MODE_DROP   = 3'd4
   } mode_type;

   mode_type                          mode_ff, mode_in;
   logic [3:0]                        nibble_ff, nibble_in;
   logic [esc_exp_pkg::COUNT_W-1:0]   count_ff, count_in;

   logic [esc_exp_pkg::COUNT_W-1:0]   count_inc;
   logic [4:0]                        hex_dec;
   logic                              hex_ok;
   logic [3:0]                        hex_val;
   logic                              esc_known;
   logic [7:0]                        esc_byte;
   logic                              done_hit;
   logic [7:0]                        done_byte;
   logic                              fail_hit;
   logic [2:0]                        fail_code;
   logic [7:0]                        in_byte;
   logic                              in_last;

   // {valid, value} of an ASCII hex digit, either case
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   assign in_byte = req_payload.in_byte;
   assign in_last = req_payload.in_last;
   assign hex_dec = hex_decode(in_byte);
   assign hex_ok  = hex_dec[4];
   assign hex_val = hex_dec[3:0];

   // Saturating count of produced bytes
   assign count_inc = (count_ff == esc_exp_pkg::COUNT_MAX) ? count_ff
                                                          : count_ff + 1'b1;

   // Single-letter escapes
   always_comb begin
      esc_known = 1'b1;
      esc_byte  = esc_exp_pkg::BYTE_NUL;
      unique case (in_byte)
         esc_exp_pkg::CHAR_ZERO:      esc_byte = esc_exp_pkg::BYTE_NUL;
         esc_exp_pkg::CHAR_BACKSLASH: esc_byte = esc_exp_pkg::CHAR_BACKSLASH;
         esc_exp_pkg::CHAR_N:         esc_byte = esc_exp_pkg::BYTE_LF;
         esc_exp_pkg::CHAR_T:         esc_byte = esc_exp_pkg::BYTE_TAB;
         esc_exp_pkg::CHAR_R:         esc_byte = esc_exp_pkg::BYTE_CR;
         esc_exp_pkg::CHAR_LBRACKET:  esc_byte = esc_exp_pkg::CHAR_LBRACKET;
         esc_exp_pkg::CHAR_RBRACKET:  esc_byte = esc_exp_pkg::CHAR_RBRACKET;
         default:                     esc_known = 1'b0;
      endcase
   end

   // Next state and result for the accepted byte
   always_comb begin
      mode_in     = mode_ff;
      nibble_in   = nibble_ff;
      count_in    = count_ff;
      res_valid   = 1'b0;
      res_payload = '0;
      done_hit    = 1'b0;
      done_byte   = esc_exp_pkg::BYTE_NUL;
      fail_hit    = 1'b0;
      fail_code   = esc_exp_pkg::ERR_NONE;

      if (req_accept) begin
         unique case (mode_ff)
            MODE_NORMAL: begin
               if (in_byte == esc_exp_pkg::CHAR_BACKSLASH) begin
                  if (in_last) begin
                     fail_hit  = 1'b1;
                     fail_code = esc_exp_pkg::ERR_ESC_CUT;
                  end else begin
                     mode_in = MODE_ESC;
                  end
               end else begin
                  res_valid   = 1'b1;
                  res_payload = '{out_byte: in_byte, error_code: esc_exp_pkg::ERR_NONE,
                                  end_of_string: in_last};
                  if (in_last) begin
                     nibble_in = 4'd0;
                     count_in  = '0;
                  end else begin
                     count_in  = count_inc;
                  end
               end
            end
            MODE_ESC: begin
               if (esc_known) begin
                  done_hit  = 1'b1;
                  done_byte = esc_byte;
               end else if (in_byte == esc_exp_pkg::CHAR_X) begin
                  if (in_last) begin
                     fail_hit  = 1'b1;
                     fail_code = esc_exp_pkg::ERR_HEX_CUT;
                  end else begin
                     mode_in = MODE_HEX1;
                  end
               end else begin
                  fail_hit  = 1'b1;
                  fail_code = esc_exp_pkg::ERR_UNKNOWN_ESC;
               end
            end
            MODE_HEX1: begin
               // cut-off check wins over the digit check
               if (in_last) begin
                  fail_hit  = 1'b1;
                  fail_code = esc_exp_pkg::ERR_HEX_CUT;
               end else if (!hex_ok) begin
                  fail_hit  = 1'b1;
                  fail_code = esc_exp_pkg::ERR_BAD_HEX;
               end else begin
                  nibble_in = hex_val;
                  mode_in   = MODE_HEX2;
               end
            end
            MODE_HEX2: begin
               if (!hex_ok) begin
                  fail_hit  = 1'b1;
                  fail_code = esc_exp_pkg::ERR_BAD_HEX;
               end else begin
                  done_hit  = 1'b1;
                  done_byte = {nibble_ff, hex_val};
               end
            end
            default: begin
               // dropping the rest of a failed string
               if (in_last) begin
                  mode_in   = MODE_NORMAL;
                  nibble_in = 4'd0;
                  count_in  = '0;
               end else begin
                  mode_in   = MODE_DROP;
               end
            end
         endcase

         // Completed escape: bump count, then check the length limit
         if (done_hit) begin
            if (count_inc >= max_length) begin
               fail_hit  = 1'b1;
               fail_code = esc_exp_pkg::ERR_LENGTH;
            end else begin
               res_valid   = 1'b1;
               res_payload = '{out_byte: done_byte, error_code: esc_exp_pkg::ERR_NONE,
                               end_of_string: in_last};
               mode_in     = MODE_NORMAL;
               if (in_last) begin
                  nibble_in = 4'd0;
                  count_in  = '0;
               end else begin
                  count_in  = count_inc;
               end
            end
         end

         // Error: report once, then drop to the end of the string
         if (fail_hit) begin
            res_valid   = 1'b1;
            res_payload = '{out_byte: esc_exp_pkg::BYTE_NUL, error_code: fail_code,
                            end_of_string: 1'b1};
            mode_in     = in_last ? MODE_NORMAL : MODE_DROP;
            nibble_in   = 4'd0;
            count_in    = '0;
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         nibble_ff <= 4'd0;
         count_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         nibble_ff <= nibble_in;
         count_ff  <= count_in;
      end
   end

   // Assertions
   a_last_returns_normal: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.in_last |=> mode_ff == MODE_NORMAL && count_ff == '0)
      else $error("final byte did not return decoder to normal");

   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_DROP |-> !res_valid)
      else $error("result produced while dropping");

   a_fail_clears_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && res_valid && res_payload.error_code != esc_exp_pkg::ERR_NONE
      |=> count_ff == '0 && nibble_ff == 4'd0)
      else $error("error did not clear count");

endmodule

FILE: src/escape_sequence_expander_top.sv
// A result is registered and shown in the cycle after its request is accepted.
// Throughput: 1 request per cycle while the result channel is not stalled.
// A request is taken while the result register is empty or being drained.
// Reset (synchronous): normal mode, count and nibble cleared, max_length = 0x7FFFFFFF,
// result register empty.
// ----------------------------------------------------------------------------
// escape_sequence_expander_top
// Backslash escape expander with APB-style max_length register.
// ----------------------------------------------------------------------------
module escape_sequence_expander_top (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  esc_exp_pkg::req_type                    req_payload,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output esc_exp_pkg::rsp_type                    rsp_payload,
   // configuration port
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [esc_exp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [esc_exp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [esc_exp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                    csr_pready
);

   logic [esc_exp_pkg::COUNT_W-1:0]   max_length_ff;
   logic                              csr_write;
   logic                              csr_hit;

   logic                              req_accept;
   logic                              res_valid;
   esc_exp_pkg::rsp_type              res_payload;

   logic                              rsp_valid_ff;
   esc_exp_pkg::rsp_type              rsp_payload_ff;

   // CSR access
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[esc_exp_pkg::CSR_ADDR_W-1] ==
                        esc_exp_pkg::CSR_IDX_MAX_LENGTH);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? {1'b0, max_length_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= esc_exp_pkg::COUNT_MAX;
      end else if (csr_write && csr_hit) begin
         max_length_ff <= csr_pwdata[esc_exp_pkg::COUNT_W-1:0];
      end
   end

   // Take a request when the result register is free or draining
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   esc_exp_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_payload (req_payload),
      .max_length  (max_length_ff),
      .res_valid   (res_valid),
      .res_payload (res_payload)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= res_valid;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && res_valid) begin
         rsp_payload_ff <= res_payload;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Assertions
   a_err_ends_string: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.error_code != esc_exp_pkg::ERR_NONE
      |-> rsp_payload.end_of_string && rsp_payload.out_byte == esc_exp_pkg::BYTE_NUL)
      else $error("error result without end_of_string or with data");

   a_err_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.error_code <= esc_exp_pkg::ERR_LENGTH)
      else $error("error code out of range");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

FILE: sim/tb_escape_sequence_expander_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_escape_sequence_expander_top
// Self-checking bench for the backslash escape expander: directed strings for
// every escape and error case, then random strings that are mostly well formed,
// checked against a cycle-free decoder model at each accepted result.
// ----------------------------------------------------------------------------
module tb_escape_sequence_expander_top;

   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned HOLD_CYCLES = 250;
   localparam int unsigned LIMIT_W = esc_exp_pkg::COUNT_W;
   // byte address of the length register: index times four
   localparam logic [esc_exp_pkg::CSR_ADDR_W-1:0] MAX_LENGTH_ADDR =
      {esc_exp_pkg::CSR_IDX_MAX_LENGTH, 2'b00};

   // decoder model states
   typedef enum logic [2:0] {
      DEC_PLAIN,
      DEC_AFTER_BSLASH,
      DEC_HEX_FIRST,
      DEC_HEX_SECOND,
      DEC_DISCARD
   } dec_mode_type;

   // the seven single-letter escapes
   localparam logic [7:0] ESC_LETTERS [7] = '{esc_exp_pkg::CHAR_ZERO,
                                              esc_exp_pkg::CHAR_BACKSLASH,
                                              esc_exp_pkg::CHAR_N,
                                              esc_exp_pkg::CHAR_T,
                                              esc_exp_pkg::CHAR_R,
                                              esc_exp_pkg::CHAR_LBRACKET,
                                              esc_exp_pkg::CHAR_RBRACKET};

   // DUT ports
   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   esc_exp_pkg::req_type                 req_payload = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   esc_exp_pkg::rsp_type                 rsp_payload;
   logic                                 csr_psel = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite = 1'b0;
   logic [esc_exp_pkg::CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [esc_exp_pkg::CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [esc_exp_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                                 csr_pready;

   // decoder model state and its copy of the length register
   dec_mode_type                      dec_mode = DEC_PLAIN;
   logic [3:0]                        hex_hi = '0;
   logic [esc_exp_pkg::COUNT_W-1:0]   out_count = '0;
   logic [esc_exp_pkg::COUNT_W-1:0]   length_limit = esc_exp_pkg::COUNT_MAX;

   // bench bookkeeping
   esc_exp_pkg::req_type     pending_reqs [$];
   esc_exp_pkg::rsp_type     expected_rsps [$];
   int unsigned pushed_count = 0;
   int unsigned taken_count = 0;
   int unsigned fail_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int          phase_num = -1;
   logic        hold_rsp = 1'b0;

   escape_sequence_expander_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Clock and reset
   always #5 clock = ~clock;

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------------
   function automatic bit hex_value(input logic [7:0] c, output logic [3:0] v);
      v = '0;
      if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);        // 0-9
      else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);   // a-f
      else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);   // A-F
      else return 1'b0;
      return 1'b1;
   endfunction

   function automatic void close_string();
      dec_mode = DEC_PLAIN;
      hex_hi = '0;
      out_count = '0;
   endfunction

   // error ends the string; without in_last the rest of it is discarded
   function automatic esc_exp_pkg::rsp_type error_rsp(input logic [2:0] code,
                                                      input logic last);
      esc_exp_pkg::rsp_type r;
      close_string();
      if (!last) dec_mode = DEC_DISCARD;
      r.out_byte = '0;
      r.error_code = code;
      r.end_of_string = 1'b1;
      return r;
   endfunction

   // only completed escapes are checked against the length limit
   function automatic esc_exp_pkg::rsp_type escape_rsp(input logic [7:0] value,
                                                       input logic last);
      esc_exp_pkg::rsp_type r;
      if (out_count != esc_exp_pkg::COUNT_MAX) out_count = out_count + 1'b1;
      if (out_count >= length_limit) return error_rsp(esc_exp_pkg::ERR_LENGTH, last);
      if (last) close_string();
      else dec_mode = DEC_PLAIN;
      r = {value, esc_exp_pkg::ERR_NONE, last};
      return r;
   endfunction

   // returns 1 when the request yields a result
   function automatic bit expand_request(input esc_exp_pkg::req_type req,
                                         output esc_exp_pkg::rsp_type res);
      logic [3:0] nib;
      res = '0;
      case (dec_mode)
         DEC_PLAIN: begin
            if (req.in_byte == esc_exp_pkg::CHAR_BACKSLASH) begin
               if (req.in_last) begin
                  res = error_rsp(esc_exp_pkg::ERR_ESC_CUT, 1'b1);
                  return 1'b1;
               end
               dec_mode = DEC_AFTER_BSLASH;
               return 1'b0;
            end
            if (out_count != esc_exp_pkg::COUNT_MAX) out_count = out_count + 1'b1;
            res = {req.in_byte, esc_exp_pkg::ERR_NONE, req.in_last};
            if (req.in_last) close_string();
            return 1'b1;
         end
         DEC_AFTER_BSLASH: begin
            if (req.in_byte == esc_exp_pkg::CHAR_X) begin
               if (req.in_last) begin
                  res = error_rsp(esc_exp_pkg::ERR_HEX_CUT, 1'b1);
                  return 1'b1;
               end
               dec_mode = DEC_HEX_FIRST;
               return 1'b0;
            end
            case (req.in_byte)
               esc_exp_pkg::CHAR_ZERO:
                  res = escape_rsp(esc_exp_pkg::BYTE_NUL, req.in_last);
               esc_exp_pkg::CHAR_BACKSLASH:
                  res = escape_rsp(esc_exp_pkg::CHAR_BACKSLASH, req.in_last);
               esc_exp_pkg::CHAR_N:
                  res = escape_rsp(esc_exp_pkg::BYTE_LF, req.in_last);
               esc_exp_pkg::CHAR_T:
                  res = escape_rsp(esc_exp_pkg::BYTE_TAB, req.in_last);
               esc_exp_pkg::CHAR_R:
                  res = escape_rsp(esc_exp_pkg::BYTE_CR, req.in_last);
               esc_exp_pkg::CHAR_LBRACKET:
                  res = escape_rsp(esc_exp_pkg::CHAR_LBRACKET, req.in_last);
               esc_exp_pkg::CHAR_RBRACKET:
                  res = escape_rsp(esc_exp_pkg::CHAR_RBRACKET, req.in_last);
               default:
                  res = error_rsp(esc_exp_pkg::ERR_UNKNOWN_ESC, req.in_last);
            endcase
            return 1'b1;
         end
         DEC_HEX_FIRST: begin
            // cut-off wins over a bad digit
            if (req.in_last) begin
               res = error_rsp(esc_exp_pkg::ERR_HEX_CUT, 1'b1);
               return 1'b1;
            end
            if (!hex_value(req.in_byte, nib)) begin
               res = error_rsp(esc_exp_pkg::ERR_BAD_HEX, 1'b0);
               return 1'b1;
            end
            hex_hi = nib;
            dec_mode = DEC_HEX_SECOND;
            return 1'b0;
         end
         DEC_HEX_SECOND: begin
            if (!hex_value(req.in_byte, nib))
               res = error_rsp(esc_exp_pkg::ERR_BAD_HEX, req.in_last);
            else res = escape_rsp({hex_hi, nib}, req.in_last);
            return 1'b1;
         end
         default: begin
            if (req.in_last) close_string();
            return 1'b0;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result ready, with random stalls and the long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin : rsp_hold_off
      wait (phase_num == 1);
      repeat (20) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Monitor: check results first, then record the new request's expectation
   // ------------------------------------------------------------------------
   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin : check_results
      esc_exp_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t ns: unexpected result, expected none actual %h",
                        $time, rsp_payload);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.out_byte !== want.out_byte)
                  report_field("out_byte", 32'(want.out_byte),
                               32'(rsp_payload.out_byte));
               if (rsp_payload.error_code !== want.error_code)
                  report_field("error_code", 32'(want.error_code),
                               32'(rsp_payload.error_code));
               if (rsp_payload.end_of_string !== want.end_of_string)
                  report_field("end_of_string", 32'(want.end_of_string),
                               32'(rsp_payload.end_of_string));
            end
         end
         if (req_valid && req_ready) begin
            taken_count++;
            if (expand_request(req_payload, want)) expected_rsps.push_back(want);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b, input logic last);
      esc_exp_pkg::req_type r;
      r.in_byte = b;
      r.in_last = last;
      pending_reqs.push_back(r);
      pushed_count++;
   endtask

   function automatic logic [7:0] random_hex_char();
      logic [3:0] v;
      v = 4'($urandom_range(15));
      if (v < 10) return 8'h30 + {4'd0, v};
      return (($urandom_range(1) == 1) ? 8'h61 : 8'h41) + {4'd0, v} - 8'd10;
   endfunction

   function automatic logic [7:0] random_non_hex();
      logic [7:0] b;
      logic [3:0] v;
      do b = 8'($urandom_range(255)); while (hex_value(b, v));
      return b;
   endfunction

   // one string: mostly valid segments, a few broken ones and raw noise
   task automatic add_random_string();
      logic [7:0] text [$];
      logic [7:0] b;
      int         segs;
      int         pick;
      bit         cut;
      bit         ok;
      segs = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(8, 1);
      cut = 1'b0;
      for (int n = 0; n < segs && !cut; n++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            b = 8'($urandom_range(255));
            if (b == esc_exp_pkg::CHAR_BACKSLASH) b = ~b;
            text.push_back(b);
         end else if (pick < 75) begin
            text.push_back(esc_exp_pkg::CHAR_BACKSLASH);
            text.push_back(ESC_LETTERS[$urandom_range(6)]);
         end else if (pick < 90) begin
            text.push_back(esc_exp_pkg::CHAR_BACKSLASH);
            text.push_back(esc_exp_pkg::CHAR_X);
            text.push_back(random_hex_char());
            text.push_back(random_hex_char());
         end else begin
            case (pick)
               90, 91: begin   // unknown escape letter
                  do begin
                     b = 8'($urandom_range(255));
                     ok = (b != esc_exp_pkg::CHAR_X);
                     foreach (ESC_LETTERS[i]) if (b == ESC_LETTERS[i]) ok = 1'b0;
                  end while (!ok);
                  text.push_back(esc_exp_pkg::CHAR_BACKSLASH);
                  text.push_back(b);
               end
               92, 93: begin   // bad first hex digit
                  text.push_back(esc_exp_pkg::CHAR_BACKSLASH);
                  text.push_back(esc_exp_pkg::CHAR_X);
                  text.push_back(random_non_hex());
               end
               94: begin       // bad second hex digit
                  text.push_back(esc_exp_pkg::CHAR_BACKSLASH);
                  text.push_back(esc_exp_pkg::CHAR_X);
                  text.push_back(random_hex_char());
                  text.push_back(random_non_hex());
               end
               95: begin       // string ends right after the backslash
                  text.push_back(esc_exp_pkg::CHAR_BACKSLASH);
                  cut = 1'b1;
               end
               96: begin       // string ends after \x
                  text.push_back(esc_exp_pkg::CHAR_BACKSLASH);
                  text.push_back(esc_exp_pkg::CHAR_X);
                  cut = 1'b1;
               end
               97: begin       // string ends after \xH
                  text.push_back(esc_exp_pkg::CHAR_BACKSLASH);
                  text.push_back(esc_exp_pkg::CHAR_X);
                  text.push_back(random_hex_char());
                  cut = 1'b1;
               end
               default: text.push_back(8'($urandom_range(255)));
            endcase
         end
      end
      foreach (text[i]) push_byte(text[i], i == text.size() - 1);
   endtask

   // write the length register and read it back; block must be idle
   task automatic set_length_limit(input logic [esc_exp_pkg::COUNT_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= MAX_LENGTH_ADDR;
      csr_pwdata <= {1'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // straight into the read setup
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {1'b0, value}) begin
         $display("%0t ns: max_length readback mismatch, expected %h actual %h",
                  $time, {1'b0, value}, csr_prdata);
         fail_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      length_limit = value;
   endtask

   // all requests taken and all results seen, then a quiet drain wait
   task automatic wait_drained();
      while (taken_count != pushed_count || expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [esc_exp_pkg::COUNT_W-1:0] limit,
                            input int unsigned s_idle,
                            input int unsigned r_idle, input int unsigned n_items);
      int unsigned target;
      set_length_limit(limit);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      phase_num++;
      target = pushed_count + n_items;
      while (pushed_count < target) add_random_string();
      wait_drained();
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      wait (!reset);
      send_idle_pct = 38;
      recv_idle_pct = 81;
      set_length_limit(esc_exp_pkg::COUNT_MAX);

      // byte extremes pass through
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);
      // every single-letter escape in one string
      foreach (ESC_LETTERS[i]) begin
         push_byte(esc_exp_pkg::CHAR_BACKSLASH, 1'b0);
         push_byte(ESC_LETTERS[i], i == 6);
      end
      // hex escape, mixed case digits
      push_byte(esc_exp_pkg::CHAR_BACKSLASH, 1'b0);
      push_byte(esc_exp_pkg::CHAR_X, 1'b0);
      push_byte(8'h61, 1'b0);
      push_byte(8'h46, 1'b1);
      // backslash as the final byte
      push_byte(esc_exp_pkg::CHAR_BACKSLASH, 1'b1);
      // hex escape cut off
      push_byte(esc_exp_pkg::CHAR_BACKSLASH, 1'b0);
      push_byte(esc_exp_pkg::CHAR_X, 1'b1);
      // unknown escape mid-string, remainder discarded
      push_byte(esc_exp_pkg::CHAR_BACKSLASH, 1'b0);
      push_byte(8'h71, 1'b0);
      push_byte(8'h5A, 1'b1);
      // bad second hex digit on the final byte
      push_byte(esc_exp_pkg::CHAR_BACKSLASH, 1'b0);
      push_byte(esc_exp_pkg::CHAR_X, 1'b0);
      push_byte(8'h31, 1'b0);
      push_byte(8'h7A, 1'b1);
      wait_drained();

      // plain byte counts, the escape after it hits the limit
      set_length_limit(2);
      push_byte(8'h61, 1'b0);
      push_byte(esc_exp_pkg::CHAR_BACKSLASH, 1'b0);
      push_byte(esc_exp_pkg::CHAR_N, 1'b1);
      wait_drained();

      // random strings over several limits and idle mixes
      run_phase(1, 38, 81, 300);
      run_phase(4, 38, 81, 330);
      run_phase(LIMIT_W'($urandom_range(12, 2)), 81, 38, 300);
      run_phase(2, 81, 38, 300);
      run_phase(LIMIT_W'($urandom_range(40, 3)), 0, 0, 320);
      run_phase(esc_exp_pkg::COUNT_MAX, 0, 0, 350);

      if (fail_count == 0) $display("PASS escape_sequence_expander_top");
      else $display("FAIL escape_sequence_expander_top");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("FAIL escape_sequence_expander_top");
      $finish;
   end

endmodule

FILE: files.f
src/esc_exp_pkg.sv
src/esc_exp_decode.sv
src/escape_sequence_expander_top.sv
sim/tb_escape_sequence_expander_top.sv
